### rtl/protobuf_field_parser_defines.svh
// assertion macros shared by the checker of the protobuf field parser
// depends on nothing; included by the files that assert
`ifndef PROTOBUF_FIELD_PARSER_DEFINES_SVH
`define PROTOBUF_FIELD_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("protobuf field parser check failed");

// next-cycle implication, checked out of reset
`define PFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("protobuf field parser check failed");

`endif

### rtl/pfp_pkg.sv
// types and constants of the protobuf field parser
// depends on nothing; used by every module of the block
package pfp_pkg;

	localparam int LEN_W     = 16;
	localparam int FIELD_W   = 29;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = Q_PTR_W + 1;

	localparam logic [2:0] WIRE_VARINT = 3'd0;
	localparam logic [2:0] WIRE_FIX64  = 3'd1;
	localparam logic [2:0] WIRE_BYTES  = 3'd2;
	localparam logic [2:0] WIRE_FIX32  = 3'd5;

	typedef enum logic [2:0] {
		K_VARINT  = 3'd0,
		K_HEADER  = 3'd1,
		K_PAYLOAD = 3'd2,
		K_ERROR   = 3'd3,
		K_END     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		E_ZERO_FIELD = 2'd0,
		E_BAD_WIRE   = 2'd1,
		E_TOO_LONG   = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_VALUE   = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_SKIP    = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	// classified byte from the front to the back
	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             past_end;
		logic             last;
		logic [LEN_W-1:0] left;
	} byte_ent_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] field;
		logic [2:0]         wtype;
		logic [31:0]        value;
		logic [LEN_W-1:0]   length;
		logic [7:0]         payload;
		logic               payload_last;
		err_t               err;
		logic               msg_end;
	} res_ent_t;

endpackage

### rtl/pfp_byte_queue.sv
// short queue of classified bytes between the front and the back
// depends on pfp_pkg
module pfp_byte_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfp_pkg::byte_ent_t wdata,
	output logic              full,
	input  logic              pop,
	output pfp_pkg::byte_ent_t rdata,
	output logic              empty
);

	pfp_pkg::byte_ent_t                 ent_q [pfp_pkg::Q_DEPTH];
	logic [pfp_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [pfp_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [pfp_pkg::Q_CNT_W-1:0]        cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (cnt_q == pfp_pkg::Q_CNT_W'(pfp_pkg::Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= wdata;
	end

endmodule

### rtl/pfp_result_queue.sv
// output queue of finished results, read from the result ports
// depends on pfp_pkg
module pfp_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfp_pkg::res_ent_t wdata,
	output logic              full,
	input  logic              pop,
	output pfp_pkg::res_ent_t rdata,
	output logic              empty
);

	pfp_pkg::res_ent_t           ent_q [pfp_pkg::Q_DEPTH];
	logic [pfp_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [pfp_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [pfp_pkg::Q_CNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (cnt_q == pfp_pkg::Q_CNT_W'(pfp_pkg::Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= wdata;
	end

endmodule

### rtl/pfp_front.sv
// front end: tracks the byte position and marks first, last and past-end bytes
// depends on pfp_pkg
module pfp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [7:0]                data_byte,
	input  logic [pfp_pkg::LEN_W-1:0] message_length,
	input  logic                      first_byte,
	output pfp_pkg::byte_ent_t        ent
);

	logic [pfp_pkg::LEN_W-1:0] pos_q;
	logic [pfp_pkg::LEN_W-1:0] pos;
	logic [pfp_pkg::LEN_W:0]   after;
	logic                      past;

	assign pos   = first_byte ? '0 : pos_q;
	assign past  = (pos >= message_length);
	assign after = {1'b0, pos} + 1'b1;

	always_comb begin
		ent          = '0;
		ent.data     = data_byte;
		ent.first    = first_byte;
		ent.past_end = past;
		ent.last     = !past && (after == {1'b0, message_length});
		// bytes left after this one, only meaningful when not past the end
		ent.left     = message_length - after[pfp_pkg::LEN_W-1:0];
	end

	// the position freezes past the end; the back stops until a new message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (accept)
			pos_q <= past ? pos : after[pfp_pkg::LEN_W-1:0];
	end

endmodule

### rtl/pfp_back.sv
// back end: varint collection, tag decode, field and payload sequencing
// depends on pfp_pkg
module pfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pfp_pkg::byte_ent_t ent,
	output logic               in_pop,
	input  logic               res_full,
	output logic               res_push,
	output pfp_pkg::res_ent_t  res
);

	pfp_pkg::phase_t                phase_q, phase_d;
	logic [31:0]                    acc_q, acc_d;
	logic [2:0]                     grp_q, grp_d;
	logic [pfp_pkg::FIELD_W-1:0]    field_q, field_d;
	logic [2:0]                     wire_q, wire_d;
	logic [pfp_pkg::LEN_W-1:0]      rem_q, rem_d;

	pfp_pkg::phase_t                ph;
	logic [31:0]                    acc;
	logic [2:0]                     grp;
	logic [31:0]                    grp_bits;
	logic [31:0]                    v;
	logic [pfp_pkg::LEN_W-1:0]      rem_n;
	logic                           done;
	logic                           have;
	logic                           stop;
	logic                           fire;

	assign fire   = in_valid && !res_full;
	assign in_pop = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfp_pkg::PH_TAG;
			acc_q   <= '0;
			grp_q   <= '0;
			field_q <= '0;
			wire_q  <= '0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			grp_q   <= grp_d;
			field_q <= field_d;
			wire_q  <= wire_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		ph       = phase_q;
		acc      = acc_q;
		grp      = grp_q;
		field_d  = field_q;
		wire_d   = wire_q;
		rem_d    = rem_q;
		if (ent.first) begin
			ph      = pfp_pkg::PH_TAG;
			acc     = '0;
			grp     = '0;
			field_d = '0;
			wire_d  = '0;
			rem_d   = '0;
		end

		case (grp)
			3'd0:    grp_bits = {25'd0, ent.data[6:0]};
			3'd1:    grp_bits = {18'd0, ent.data[6:0], 7'd0};
			3'd2:    grp_bits = {11'd0, ent.data[6:0], 14'd0};
			3'd3:    grp_bits = {4'd0, ent.data[6:0], 21'd0};
			3'd4:    grp_bits = {ent.data[3:0], 28'd0};
			default: grp_bits = '0;
		endcase
		v     = acc | grp_bits;
		done  = !ent.data[7] || (grp == 3'd4);
		rem_n = (rem_d != '0) ? rem_d - 1'b1 : rem_d;

		phase_d  = ph;
		acc_d    = acc;
		grp_d    = grp;
		res      = '0;
		have     = 1'b0;
		stop     = 1'b0;
		res_push = 1'b0;

		if (!fire) begin
			phase_d = phase_q;
			acc_d   = acc_q;
			grp_d   = grp_q;
			field_d = field_q;
			wire_d  = wire_q;
			rem_d   = rem_q;
		end else if (ph == pfp_pkg::PH_DONE) begin
			phase_d = pfp_pkg::PH_DONE;
		end else if (ent.past_end) begin
			phase_d = pfp_pkg::PH_DONE;
		end else begin
			case (ph)
				pfp_pkg::PH_TAG, pfp_pkg::PH_VALUE, pfp_pkg::PH_LEN: begin
					if (!done && !ent.last) begin
						acc_d = v;
						grp_d = grp + 1'b1;
					end else begin
						// varint complete, or cut short by the message end
						acc_d = '0;
						grp_d = '0;
						case (ph)
							pfp_pkg::PH_TAG: begin
								field_d = v[31:3];
								wire_d  = v[2:0];
								if (v[31:3] == '0) begin
									res.kind = pfp_pkg::K_ERROR;
									res.err  = pfp_pkg::E_ZERO_FIELD;
									have     = 1'b1;
									stop     = 1'b1;
								end else if (v[2:0] == pfp_pkg::WIRE_VARINT) begin
									if (ent.last) begin
										res.kind = pfp_pkg::K_VARINT;
										have     = 1'b1;
									end else
										phase_d = pfp_pkg::PH_VALUE;
								end else if (v[2:0] == pfp_pkg::WIRE_BYTES) begin
									if (ent.last) begin
										res.kind = pfp_pkg::K_HEADER;
										have     = 1'b1;
									end else
										phase_d = pfp_pkg::PH_LEN;
								end else if (v[2:0] == pfp_pkg::WIRE_FIX32) begin
									rem_d   = pfp_pkg::LEN_W'(4);
									phase_d = pfp_pkg::PH_SKIP;
								end else if (v[2:0] == pfp_pkg::WIRE_FIX64) begin
									rem_d   = pfp_pkg::LEN_W'(8);
									phase_d = pfp_pkg::PH_SKIP;
								end else begin
									res.kind = pfp_pkg::K_ERROR;
									res.err  = pfp_pkg::E_BAD_WIRE;
									have     = 1'b1;
									stop     = 1'b1;
								end
							end
							pfp_pkg::PH_VALUE: begin
								res.kind  = pfp_pkg::K_VARINT;
								res.value = v;
								have      = 1'b1;
								phase_d   = pfp_pkg::PH_TAG;
							end
							default: begin
								if (v > {16'd0, ent.left}) begin
									res.kind = pfp_pkg::K_ERROR;
									res.err  = pfp_pkg::E_TOO_LONG;
									have     = 1'b1;
									stop     = 1'b1;
								end else begin
									res.kind   = pfp_pkg::K_HEADER;
									res.length = v[pfp_pkg::LEN_W-1:0];
									have       = 1'b1;
									rem_d      = v[pfp_pkg::LEN_W-1:0];
									phase_d    = (v == '0) ? pfp_pkg::PH_TAG
										: pfp_pkg::PH_PAYLOAD;
								end
							end
						endcase
					end
				end
				pfp_pkg::PH_PAYLOAD: begin
					rem_d            = rem_n;
					res.kind         = pfp_pkg::K_PAYLOAD;
					res.payload      = ent.data;
					res.payload_last = (rem_n == '0);
					have             = 1'b1;
					if (rem_n == '0)
						phase_d = pfp_pkg::PH_TAG;
				end
				default: begin
					// skipping a fixed-width field
					rem_d = rem_n;
					if (rem_n == '0)
						phase_d = pfp_pkg::PH_TAG;
				end
			endcase

			if (have) begin
				res.field = field_d;
				res.wtype = wire_d;
			end
			if (ent.last && !have) begin
				res.kind = pfp_pkg::K_END;
				have     = 1'b1;
			end
			if (stop || ent.last)
				phase_d = pfp_pkg::PH_DONE;
			res.msg_end = ent.last;
			res_push    = have;
		end
	end

endmodule

### rtl/protobuf_field_parser.sv
// protobuf field parser: one message byte per cycle in while not full, at most one
// result per byte out; bytes are registered in the byte queue, results in the result
// queue; one byte per cycle, set by the single-step back end over a four-entry byte queue
// full rises only when the byte queue fills because results are not popped
// reset (arst_n low) empties both queues and returns the parser to the tag phase
module protobuf_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [15:0] message_length,
	input  logic        first_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [28:0] field_number,
	output logic [2:0]  wire_type,
	output logic [31:0] value,
	output logic [15:0] length,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [1:0]  error_code,
	output logic        message_end
);

	pfp_pkg::byte_ent_t front_ent;
	pfp_pkg::byte_ent_t back_ent;
	pfp_pkg::res_ent_t  back_res;
	pfp_pkg::res_ent_t  out_res;
	logic               accept;
	logic               bq_empty;
	logic               bq_pop;
	logic               rq_full;
	logic               rq_push;

	assign accept = push && !full;

	pfp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.message_length (message_length),
		.first_byte     (first_byte),
		.ent            (front_ent)
	);

	pfp_byte_queue u_byte_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_ent),
		.full   (full),
		.pop    (bq_pop),
		.rdata  (back_ent),
		.empty  (bq_empty)
	);

	pfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!bq_empty),
		.ent      (back_ent),
		.in_pop   (bq_pop),
		.res_full (rq_full),
		.res_push (rq_push),
		.res      (back_res)
	);

	pfp_result_queue u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (back_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign kind         = out_res.kind;
	assign field_number = out_res.field;
	assign wire_type    = out_res.wtype;
	assign value        = out_res.value;
	assign length       = out_res.length;
	assign payload_byte = out_res.payload;
	assign payload_last = out_res.payload_last;
	assign error_code   = out_res.err;
	assign message_end  = out_res.msg_end;

endmodule

### rtl/pfp_checker.sv
// port-level checks of the protobuf field parser, bound to the top level
// depends on pfp_pkg and protobuf_field_parser_defines.svh
`include "protobuf_field_parser_defines.svh"

module pfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  kind,
	input logic [28:0] field_number,
	input logic [31:0] value,
	input logic [7:0]  payload_byte,
	input logic        payload_last,
	input logic [1:0]  error_code,
	input logic        message_end
);

	// a waiting result stays put until it is transferred
	`PFP_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(kind) && $stable(value) && $stable(payload_byte))

	// last-payload flag only on payload results
	`PFP_ASSERT_NOW(a_plast, clk, arst_n, !empty && payload_last, kind == pfp_pkg::K_PAYLOAD)

	// the error code is zero on every result that is not an error result
	`PFP_ASSERT_NOW(a_err, clk, arst_n, !empty && kind != pfp_pkg::K_ERROR, error_code == pfp_pkg::E_ZERO_FIELD)

	// an end result always comes from the last byte of a message
	`PFP_ASSERT_NOW(a_end, clk, arst_n, !empty && kind == pfp_pkg::K_END, message_end && field_number == '0)

endmodule

bind protobuf_field_parser pfp_checker u_pfp_checker (.*);
